@@ design/pwmds_pkg.sv @@
// ----------------------------------------------------------------------------
// pwmds_pkg
// Shared widths, limits, status codes and divider request/response types
// for the PWM timer divisor search.
// ----------------------------------------------------------------------------
package pwmds_pkg;

  localparam int unsigned FreqW  = 27;  // target frequency, 0.1 Hz units
  localparam int unsigned ClkW   = 29;  // timer input clock, Hz
  localparam int unsigned CandW  = 30;  // candidate tick rate, holds clk + step
  localparam int unsigned DivNW  = 33;  // dividend width, holds 10 * (clk - 1)
  localparam int unsigned DivDW  = 29;  // divisor width
  localparam int unsigned DivQW  = 34;  // rounded quotient width
  localparam int unsigned CntW   = $clog2(DivNW + 1);
  localparam int unsigned RegW   = 16;  // prescaler / period width

  localparam logic [ClkW-1:0] ClkReset  = 29'd72000000;
  localparam int unsigned     PeriodMin = 100;
  localparam int unsigned     StepSplit = 5000;
  localparam int unsigned     Tenths    = 10;

  // n / 10 == (n * TenthRecip) >> TenthShift for any n below 2^32
  localparam logic [31:0]     TenthRecip = 32'hCCCC_CCCD;
  localparam int unsigned     TenthShift = 35;
  localparam int unsigned     RecipW     = FreqW + 32;

  typedef enum logic [1:0] {
    STAT_FOUND = 2'd0,
    STAT_NONE  = 2'd1,
    STAT_ZERO  = 2'd2
  } status_e;

  typedef struct packed {
    logic             start;
    logic [DivNW-1:0] dividend;
    logic [DivDW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DivNW-1:0] quot;
    logic             up;     // remainder above half the divisor
  } div_rsp_t;

endpackage

@@ design/pwmds_in_if.sv @@
// ----------------------------------------------------------------------------
// pwmds_in_if
// Request channel: one word carries a target PWM frequency.
// ----------------------------------------------------------------------------
interface pwmds_in_if;
  logic                         valid;
  logic                         ready;
  logic [pwmds_pkg::FreqW-1:0]  target_freq;

  modport source (output valid, output target_freq, input ready);
  modport sink   (input valid, input target_freq, output ready);
endinterface

@@ design/pwmds_out_if.sv @@
// ----------------------------------------------------------------------------
// pwmds_out_if
// Result channel: one word carries status, prescaler, period and clock_div.
// ----------------------------------------------------------------------------
interface pwmds_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [pwmds_pkg::RegW-1:0]  prescaler_value;
  logic [pwmds_pkg::RegW-1:0]  period_value;
  logic                        clock_div;

  modport source (output valid, output status, output prescaler_value,
                  output period_value, output clock_div, input ready);
  modport sink   (input valid, input status, input prescaler_value,
                  input period_value, input clock_div, output ready);
endinterface

@@ design/pwm_timer_divisor_search.sv @@
// ----------------------------------------------------------------------------
// pwm_timer_divisor_search
// Finds a timer prescaler / auto-reload pair for a requested PWM frequency.
// ----------------------------------------------------------------------------
// A word on the input carries a frequency in 0.1 Hz units; one result word
// follows: status 0 with prescaler and period, status 1 when no candidate
// tick rate qualifies, or status 2 for a zero frequency (answered without
// a search). The search runs one candidate at a time through a single
// bit-serial divider: each candidate costs one to four divisions, and the
// number of candidates is bounded by the period limit and by
// system_clock_hz, up to about 65536. The input is not ready while a search
// runs or a result waits to enter the output register. system_clock_hz
// resets to 72 MHz; the user must write it through cfg_we_i / cfg_wdata_i
// only while idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module pwm_timer_divisor_search (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pwmds_pkg::ClkW-1:0]   cfg_wdata_i,
  pwmds_in_if.sink                     in_i,
  pwmds_out_if.source                  out_o
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_STEP = 8'b0000_0010,
    ST_CAND = 8'b0000_0100,
    ST_PQ   = 8'b0000_1000,
    ST_SQ   = 8'b0001_0000,
    ST_TICK = 8'b0010_0000,
    ST_CHK  = 8'b0100_0000,
    ST_EMIT = 8'b1000_0000
  } state_e;

  state_e                        state_q, state_d;
  logic [pwmds_pkg::ClkW-1:0]    clk_hz_q;
  logic [pwmds_pkg::FreqW-1:0]   freq_q, freq_d;
  logic [pwmds_pkg::FreqW-1:0]   step_q, step_d;
  logic [pwmds_pkg::CandW-1:0]   cand_q, cand_d;
  logic [pwmds_pkg::RegW-1:0]    pq_q, pq_d;
  logic [pwmds_pkg::RegW-1:0]    sq_q, sq_d;
  pwmds_pkg::status_e            res_status_q, res_status_d;
  logic [pwmds_pkg::RegW-1:0]    res_psc_q, res_psc_d;
  logic [pwmds_pkg::RegW-1:0]    res_per_q, res_per_d;

  logic                          out_valid_q, out_valid_d;
  logic [1:0]                    out_status_q, out_status_d;
  logic [pwmds_pkg::RegW-1:0]    out_psc_q, out_psc_d;
  logic [pwmds_pkg::RegW-1:0]    out_per_q, out_per_d;

  pwmds_pkg::div_req_t           div_req;
  pwmds_pkg::div_rsp_t           div_rsp;
  logic [pwmds_pkg::DivQW-1:0]   rq;
  logic [pwmds_pkg::CandW-1:0]   cand_next;
  logic [pwmds_pkg::RecipW-1:0]  step_prod;
  logic                          emit;

  pwmds_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // rounded quotient
  assign rq = pwmds_pkg::DivQW'(div_rsp.quot) + pwmds_pkg::DivQW'(div_rsp.up);
  assign cand_next = cand_q + pwmds_pkg::CandW'(step_q);
  assign emit = (state_q == ST_EMIT) && (!out_valid_q || out_o.ready);

  // freq / 10 by reciprocal multiply
  assign step_prod = pwmds_pkg::RecipW'(freq_q) * pwmds_pkg::RecipW'(pwmds_pkg::TenthRecip);

  assign in_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d      = state_q;
    freq_d       = freq_q;
    step_d       = step_q;
    cand_d       = cand_q;
    pq_d         = pq_q;
    sq_d         = sq_q;
    res_status_d = res_status_q;
    res_psc_d    = res_psc_q;
    res_per_d    = res_per_q;
    div_req      = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          freq_d       = in_i.target_freq;
          cand_d       = pwmds_pkg::CandW'(1);
          res_status_d = pwmds_pkg::STAT_NONE;
          res_psc_d    = '0;
          res_per_d    = '0;
          if (in_i.target_freq == '0) begin
            res_status_d = pwmds_pkg::STAT_ZERO;
            state_d      = ST_EMIT;
          end else if (in_i.target_freq > pwmds_pkg::FreqW'(pwmds_pkg::StepSplit)) begin
            state_d = ST_STEP;
          end else begin
            step_d  = in_i.target_freq;
            state_d = ST_CAND;
          end
        end
      end
      ST_STEP: begin
        step_d  = pwmds_pkg::FreqW'(step_prod[pwmds_pkg::RecipW-1:pwmds_pkg::TenthShift]);
        state_d = ST_CAND;
      end
      ST_CAND: begin
        if (cand_q < {1'b0, clk_hz_q}) begin
          div_req.start    = 1'b1;
          div_req.dividend = pwmds_pkg::DivNW'(cand_q[pwmds_pkg::ClkW-1:0])
                             * pwmds_pkg::DivNW'(pwmds_pkg::Tenths);
          div_req.divisor  = pwmds_pkg::DivDW'(freq_q);
          state_d          = ST_PQ;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_PQ: begin
        if (div_rsp.done) begin
          if (rq[pwmds_pkg::DivQW-1:pwmds_pkg::RegW] != '0) begin
            // period quotient only grows from here
            state_d = ST_EMIT;
          end else if (rq[pwmds_pkg::RegW-1:0] <= pwmds_pkg::RegW'(pwmds_pkg::PeriodMin)) begin
            cand_d  = cand_next;
            state_d = ST_CAND;
          end else begin
            pq_d             = rq[pwmds_pkg::RegW-1:0];
            div_req.start    = 1'b1;
            div_req.dividend = pwmds_pkg::DivNW'(clk_hz_q);
            div_req.divisor  = cand_q[pwmds_pkg::DivDW-1:0];
            state_d          = ST_SQ;
          end
        end
      end
      ST_SQ: begin
        if (div_rsp.done) begin
          if (rq[pwmds_pkg::DivQW-1:pwmds_pkg::RegW] != '0
              || rq[pwmds_pkg::RegW-1:0] < pwmds_pkg::RegW'(2)) begin
            cand_d  = cand_next;
            state_d = ST_CAND;
          end else begin
            sq_d             = rq[pwmds_pkg::RegW-1:0];
            div_req.start    = 1'b1;
            div_req.dividend = pwmds_pkg::DivNW'(clk_hz_q);
            div_req.divisor  = pwmds_pkg::DivDW'(rq[pwmds_pkg::RegW-1:0]);
            state_d          = ST_TICK;
          end
        end
      end
      ST_TICK: begin
        if (div_rsp.done) begin
          if (rq == '0) begin
            cand_d  = cand_next;
            state_d = ST_CAND;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = pwmds_pkg::DivNW'(rq[pwmds_pkg::ClkW-1:0])
                               * pwmds_pkg::DivNW'(pwmds_pkg::Tenths);
            div_req.divisor  = pwmds_pkg::DivDW'(pq_q);
            state_d          = ST_CHK;
          end
        end
      end
      ST_CHK: begin
        if (div_rsp.done) begin
          if (rq == pwmds_pkg::DivQW'(freq_q)) begin
            res_status_d = pwmds_pkg::STAT_FOUND;
            res_psc_d    = sq_q - pwmds_pkg::RegW'(1);
            res_per_d    = pq_q - pwmds_pkg::RegW'(1);
            state_d      = ST_EMIT;
          end else begin
            cand_d  = cand_next;
            state_d = ST_CAND;
          end
        end
      end
      ST_EMIT: begin
        if (emit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output word register
  always_comb begin
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_psc_d    = out_psc_q;
    out_per_d    = out_per_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d  = 1'b1;
      out_status_d = res_status_q;
      out_psc_d    = res_psc_q;
      out_per_d    = res_per_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      clk_hz_q    <= pwmds_pkg::ClkReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        clk_hz_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    freq_q       <= freq_d;
    step_q       <= step_d;
    cand_q       <= cand_d;
    pq_q         <= pq_d;
    sq_q         <= sq_d;
    res_status_q <= res_status_d;
    res_psc_q    <= res_psc_d;
    res_per_q    <= res_per_d;
    out_status_q <= out_status_d;
    out_psc_q    <= out_psc_d;
    out_per_q    <= out_per_d;
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.status          = out_status_q;
  assign out_o.prescaler_value = out_psc_q;
  assign out_o.period_value    = out_per_q;
  assign out_o.clock_div       = 1'b0;

endmodule

@@ design/pwmds_div.sv @@
// ----------------------------------------------------------------------------
// pwmds_div
// Restoring radix-2 divider, one quotient bit per cycle. Reports the
// truncated quotient and whether the remainder exceeds half the divisor.
// ----------------------------------------------------------------------------
module pwmds_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pwmds_pkg::div_req_t req_i,
  output pwmds_pkg::div_rsp_t rsp_o
);

  logic [pwmds_pkg::DivNW-1:0] quo_q, quo_d;
  logic [pwmds_pkg::DivDW-1:0] den_q, den_d;
  logic [pwmds_pkg::DivDW-1:0] rem_q, rem_d;
  logic [pwmds_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [pwmds_pkg::DivDW:0]   trial;

  always_comb begin
    trial  = {rem_q, quo_q[pwmds_pkg::DivNW-1]};
    quo_d  = quo_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      den_d  = req_i.divisor;
      rem_d  = '0;
      cnt_d  = pwmds_pkg::CntW'(pwmds_pkg::DivNW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[pwmds_pkg::DivNW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d    = pwmds_pkg::DivDW'(trial - {1'b0, den_q});
        quo_d[0] = 1'b1;
      end else begin
        rem_d = trial[pwmds_pkg::DivDW-1:0];
      end
      cnt_d = cnt_q - pwmds_pkg::CntW'(1);
      if (cnt_q == pwmds_pkg::CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.up   = rem_q > (den_q >> 1);

endmodule
